>>> hdl/fbru_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package fbru_pkg;

    typedef struct packed {
        logic [11:0] channel;
        logic [15:0] position;
        logic [15:0] src_value;
        logic [15:0] bias_value;
    } t_req;

    typedef struct packed {
        logic [15:0] dst_value;
        logic [28:0] src_addr;
        logic [27:0] dst_addr;
    } t_rsp;

    localparam logic [2:0] CFG_ACT_MODE    = 3'd0;
    localparam logic [2:0] CFG_BIAS_ENABLE = 3'd1;
    localparam logic [2:0] CFG_BLOCK_SIZE  = 3'd2;
    localparam logic [2:0] CFG_CHAN_STRIDE = 3'd3;
    localparam logic [2:0] CFG_BLOCK_PITCH = 3'd4;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_RELU  = 2'd1;
    localparam logic [1:0] ACT_RELU6 = 2'd2;

    localparam logic [12:0] MAX_CHANNELS  = 13'd4096;
    localparam logic [16:0] MAX_POSITIONS = 17'd65536;

    localparam logic [15:0] H_QNAN = 16'h7E00;
    localparam logic [15:0] H_SIX  = 16'h4600;
    localparam logic [16:0] H_INF  = 17'h07C00;

    // Reciprocal rounded up, in units of 2^-16, for the divide by block size.
    function automatic logic [16:0] recip(input logic [3:0] bs);
        logic [16:0] r;
        unique case (bs)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd32768;
            4'd3:    r = 17'd21846;
            4'd4:    r = 17'd16384;
            4'd5:    r = 17'd13108;
            4'd6:    r = 17'd10923;
            4'd7:    r = 17'd9363;
            4'd8:    r = 17'd8192;
            4'd9:    r = 17'd7282;
            4'd10:   r = 17'd6554;
            4'd11:   r = 17'd5958;
            4'd12:   r = 17'd5462;
            4'd13:   r = 17'd5042;
            4'd14:   r = 17'd4682;
            4'd15:   r = 17'd4370;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

>>> hdl/fp16_bias_relu_layout_unpack.sv
`timescale 1ns / 1ps
`default_nettype none
// A request accepted with start passes the stage 1, 2 and 3 registers and then the output
// register before its result is on the result ports, where the receiver takes it.
// Throughput: one request per cycle; busy is never raised since the pipeline has no stall.
// The four stages are operand swap, alignment and add, normalization, then rounding.
// The receiver cannot stall; each result is shown for one cycle with o_strobe.
// Reset clears the stage valid bits and loads the configuration defaults.
module fp16_bias_relu_layout_unpack (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire fbru_pkg::t_req     i_req,
    output logic                    o_strobe,
    output fbru_pkg::t_rsp          o_rsp,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_idx,
    input  wire logic [16:0]        i_cfg_data
);

    logic [1:0]  r_act_mode;
    logic        r_bias_enable;
    logic [3:0]  r_block_size;
    logic [12:0] r_chan_stride;
    logic [16:0] r_block_pitch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_mode    <= fbru_pkg::ACT_NONE;
            r_bias_enable <= 1'b1;
            r_block_size  <= 4'd8;
            r_chan_stride <= 13'd4096;
            r_block_pitch <= 17'd65536;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fbru_pkg::CFG_ACT_MODE:    r_act_mode    <= i_cfg_data[1:0];
                fbru_pkg::CFG_BIAS_ENABLE: r_bias_enable <= i_cfg_data[0];
                fbru_pkg::CFG_BLOCK_SIZE:  r_block_size  <= i_cfg_data[3:0];
                fbru_pkg::CFG_CHAN_STRIDE: r_chan_stride <= i_cfg_data[12:0];
                fbru_pkg::CFG_BLOCK_PITCH: r_block_pitch <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // Stage 1: classify, order by magnitude, divide channel by block size.
    logic        n_s1_v;
    logic        n_s1_spec;
    logic [15:0] n_s1_spec_val;
    logic        n_s1_swap;
    logic [15:0] n_s1_big;
    logic [15:0] n_s1_sml;
    logic [4:0]  n_s1_eb;
    logic [4:0]  n_s1_es;
    logic        nan_a;
    logic        nan_b;
    logic        inf_a;
    logic        inf_b;
    logic [28:0] n_s1_prod;

    always_comb begin
        nan_a = (&i_req.src_value[14:10]) && (|i_req.src_value[9:0]);
        nan_b = (&i_req.bias_value[14:10]) && (|i_req.bias_value[9:0]);
        inf_a = (i_req.src_value[14:0] == 15'h7C00);
        inf_b = (i_req.bias_value[14:0] == 15'h7C00);
        n_s1_v = accept && (r_block_size != 4'd0)
                 && ({1'b0, i_req.channel} < fbru_pkg::MAX_CHANNELS)
                 && ({1'b0, i_req.position} < fbru_pkg::MAX_POSITIONS);
        n_s1_spec     = 1'b1;
        n_s1_spec_val = i_req.src_value;
        priority if (!r_bias_enable) begin
            n_s1_spec_val = i_req.src_value;
        end else if (nan_a) begin
            n_s1_spec_val = i_req.src_value | 16'h0200;
        end else if (nan_b) begin
            n_s1_spec_val = i_req.bias_value | 16'h0200;
        end else if (inf_a && inf_b) begin
            n_s1_spec_val = (i_req.src_value[15] != i_req.bias_value[15]) ?
                            fbru_pkg::H_QNAN : i_req.src_value;
        end else if (inf_a) begin
            n_s1_spec_val = i_req.src_value;
        end else if (inf_b) begin
            n_s1_spec_val = i_req.bias_value;
        end else begin
            n_s1_spec = 1'b0;
        end
        n_s1_swap = i_req.bias_value[14:0] > i_req.src_value[14:0];
        n_s1_big  = n_s1_swap ? i_req.bias_value : i_req.src_value;
        n_s1_sml  = n_s1_swap ? i_req.src_value : i_req.bias_value;
        n_s1_eb   = (n_s1_big[14:10] == 5'd0) ? 5'd1 : n_s1_big[14:10];
        n_s1_es   = (n_s1_sml[14:10] == 5'd0) ? 5'd1 : n_s1_sml[14:10];
        n_s1_prod = 29'(i_req.channel) * 29'(fbru_pkg::recip(r_block_size));
    end

    logic        r_s1_v;
    logic        r_s1_spec;
    logic [15:0] r_s1_spec_val;
    logic        r_s1_sign;
    logic        r_s1_sub;
    logic        r_s1_zsign;
    logic [10:0] r_s1_mb;
    logic [10:0] r_s1_ms;
    logic [4:0]  r_s1_e;
    logic [4:0]  r_s1_d;
    logic [11:0] r_s1_q;
    logic [11:0] r_s1_ch;
    logic [15:0] r_s1_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= n_s1_v;
        end
        r_s1_spec     <= n_s1_spec;
        r_s1_spec_val <= n_s1_spec_val;
        r_s1_sign     <= n_s1_big[15];
        r_s1_sub      <= n_s1_big[15] ^ n_s1_sml[15];
        r_s1_zsign    <= n_s1_big[15] & n_s1_sml[15];
        r_s1_mb       <= {|n_s1_big[14:10], n_s1_big[9:0]};
        r_s1_ms       <= {|n_s1_sml[14:10], n_s1_sml[9:0]};
        r_s1_e        <= n_s1_eb;
        r_s1_d        <= n_s1_eb - n_s1_es;
        r_s1_q        <= n_s1_prod[27:16];
        r_s1_ch       <= i_req.channel;
        r_s1_pos      <= i_req.position;
    end

    // Stage 2: align the smaller operand and add.
    logic [13:0] n_s2_ext;
    logic [13:0] n_s2_shf;
    logic        n_s2_sticky;
    logic [14:0] n_s2_sum;
    logic [15:0] n_s2_qb;

    always_comb begin
        n_s2_ext    = {r_s1_ms, 3'b000};
        n_s2_shf    = n_s2_ext >> r_s1_d;
        n_s2_sticky = |(n_s2_ext & ~(14'h3FFF << r_s1_d));
        n_s2_shf[0] = n_s2_shf[0] | n_s2_sticky;
        if (r_s1_sub) begin
            n_s2_sum = {1'b0, r_s1_mb, 3'b000} - {1'b0, n_s2_shf};
        end else begin
            n_s2_sum = {1'b0, r_s1_mb, 3'b000} + {1'b0, n_s2_shf};
        end
        n_s2_qb = 16'(r_s1_q) * 16'(r_block_size);
    end

    logic        r_s2_v;
    logic        r_s2_spec;
    logic [15:0] r_s2_spec_val;
    logic        r_s2_sign;
    logic        r_s2_zsign;
    logic [14:0] r_s2_sum;
    logic [4:0]  r_s2_e;
    logic [11:0] r_s2_qb;
    logic [11:0] r_s2_ch;
    logic [15:0] r_s2_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
        r_s2_spec     <= r_s1_spec;
        r_s2_spec_val <= r_s1_spec_val;
        r_s2_sign     <= r_s1_sign;
        r_s2_zsign    <= r_s1_zsign;
        r_s2_sum      <= n_s2_sum;
        r_s2_e        <= r_s1_e;
        r_s2_qb       <= n_s2_qb[11:0];
        r_s2_ch       <= r_s1_ch;
        r_s2_pos      <= r_s1_pos;
    end

    // Stage 3: normalize, and form the address products.
    logic [3:0]  n_s3_lz;
    logic [4:0]  n_s3_lim;
    logic [3:0]  n_s3_sh;
    logic [13:0] n_s3_n;
    logic [5:0]  n_s3_e;

    always_comb begin
        n_s3_lz = 4'd14;
        for (int i = 0; i < 14; i++) begin
            if (r_s2_sum[i]) begin
                n_s3_lz = 4'(13 - i);
            end
        end
        n_s3_lim = r_s2_e - 5'd1;
        n_s3_sh  = ({1'b0, n_s3_lz} > n_s3_lim) ? n_s3_lim[3:0] : n_s3_lz;
        if (r_s2_sum[14]) begin
            n_s3_n = {r_s2_sum[14:2], r_s2_sum[1] | r_s2_sum[0]};
            n_s3_e = {1'b0, r_s2_e} + 6'd1;
        end else begin
            n_s3_n = r_s2_sum[13:0] << n_s3_sh;
            n_s3_e = {1'b0, r_s2_e} - 6'(n_s3_sh);
        end
    end

    logic        r_s3_v;
    logic        r_s3_spec;
    logic [15:0] r_s3_spec_val;
    logic        r_s3_sign;
    logic        r_s3_zero;
    logic        r_s3_zsign;
    logic [13:0] r_s3_n;
    logic [5:0]  r_s3_e;
    logic [28:0] r_s3_m1;
    logic [19:0] r_s3_m2;
    logic [3:0]  r_s3_rem;
    logic [27:0] r_s3_dm;
    logic [11:0] r_s3_ch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else begin
            r_s3_v <= r_s2_v;
        end
        r_s3_spec     <= r_s2_spec;
        r_s3_spec_val <= r_s2_spec_val;
        r_s3_sign     <= r_s2_sign;
        r_s3_zero     <= (r_s2_sum == 15'd0);
        r_s3_zsign    <= r_s2_zsign;
        r_s3_n        <= n_s3_n;
        r_s3_e        <= n_s3_e;
        r_s3_m1       <= 29'(r_s2_qb) * 29'(r_block_pitch);
        r_s3_m2       <= 20'(r_s2_pos) * 20'(r_block_size);
        r_s3_rem      <= 4'(r_s2_ch - r_s2_qb);
        r_s3_dm       <= 28'(r_s2_pos) * 28'(r_chan_stride);
        r_s3_ch       <= r_s2_ch;
    end

    // Stage 4: round, saturate, activation and address sums.
    logic        n_s4_up;
    logic [16:0] n_s4_bits;
    logic [15:0] n_s4_v;

    always_comb begin
        n_s4_up   = r_s3_n[2] && ((|r_s3_n[1:0]) || r_s3_n[3]);
        n_s4_bits = {r_s3_e[4:0] - 5'd1, 10'd0} + 17'(r_s3_n[13:3]) + 17'(n_s4_up);
        if (n_s4_bits >= fbru_pkg::H_INF) begin
            n_s4_bits = fbru_pkg::H_INF;
        end
        priority if (r_s3_spec) begin
            n_s4_v = r_s3_spec_val;
        end else if (r_s3_zero) begin
            n_s4_v = {r_s3_zsign, 15'd0};
        end else begin
            n_s4_v = {r_s3_sign, n_s4_bits[14:0]};
        end
        if (!((&n_s4_v[14:10]) && (|n_s4_v[9:0]))) begin
            if ((r_act_mode == fbru_pkg::ACT_RELU || r_act_mode == fbru_pkg::ACT_RELU6)
                && n_s4_v[15] && (n_s4_v[14:0] != 15'd0)) begin
                n_s4_v = 16'd0;
            end
            if (r_act_mode == fbru_pkg::ACT_RELU6 && !n_s4_v[15]
                && n_s4_v > fbru_pkg::H_SIX) begin
                n_s4_v = fbru_pkg::H_SIX;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r_s3_v;
        end
        o_rsp.dst_value <= n_s4_v;
        o_rsp.src_addr  <= r_s3_m1 + 29'(r_s3_m2) + 29'(r_s3_rem);
        o_rsp.dst_addr  <= r_s3_dm + 28'(r_s3_ch);
    end

`ifndef SYNTHESIS
    a_no_result_zero_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_block_size == 4'd0) |-> ##4 !o_strobe)
        else $error("result produced for zero block size");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_block_size != 4'd0) |-> ##4 o_strobe)
        else $error("accepted request produced no result");

    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_s3_v))
        else $error("strobe without a request in the last stage");
`endif

endmodule
`default_nettype wire
